### rtl/core/eshsvf_pkg.sv
// Shared types, constants and helpers for the envelope sample-and-hold dual filter.
`timescale 1ns / 1ps

package eshsvf_pkg;

    // Serial multiplier: signed A operand, unsigned B operand, one B bit per cycle.
    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = 14;
    localparam int MUL_P_W   = 32;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW        = 3'd5;

    localparam logic [31:0] RNG_SEED = 32'h1357_9BDF;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

    function automatic logic signed [19:0] clamp20(input logic signed [19:0] v,
                                                   input logic signed [19:0] lo,
                                                   input logic signed [19:0] hi);
        logic signed [19:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic signed [19:0] sx12(input logic signed [11:0] v);
        return {{8{v[11]}}, v};
    endfunction

endpackage

### rtl/core/eshsvf_in_if.sv
// Input channel: one sample word with its control levels.
`timescale 1ns / 1ps

interface eshsvf_in_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] audio_in;
    logic signed [11:0] aux_in;
    logic signed [11:0] cv_a;
    logic signed [11:0] cv_b;
    logic              clock_in;
    logic              hold_gate;
    logic              hold_switch;

    modport source (output valid, audio_in, aux_in, cv_a, cv_b, clock_in, hold_gate,
                    hold_switch, input ready);
    modport sink   (input valid, audio_in, aux_in, cv_a, cv_b, clock_in, hold_gate,
                    hold_switch, output ready);
endinterface

### rtl/core/eshsvf_out_if.sv
// Output channel: one result word per sample.
`timescale 1ns / 1ps

interface eshsvf_out_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] out_left;
    logic signed [11:0] out_right;
    logic signed [11:0] held_cv;
    logic        [11:0] envelope_cv;
    logic              clock_out;
    logic              gate_out;

    modport source (output valid, out_left, out_right, held_cv, envelope_cv, clock_out,
                    gate_out, input ready);
    modport sink   (input valid, out_left, out_right, held_cv, envelope_cv, clock_out,
                    gate_out, output ready);
endinterface

### rtl/core/envelope_sample_hold_dual_svf.sv
// Top level of the envelope-following dual state-variable filter with sample-and-hold.
`timescale 1ns / 1ps

// Each input word carries one audio sample with its aux sample, two CVs and three
// control levels; the block returns one word holding the two soft-clipped channels,
// the held random value, the envelope level, the clock echo and the divided gate.
// Every multiplication of the sample's work, from knob scaling to the two Chamberlin
// filters and the ping-pong pan, runs on a single bit-serial multiplier that consumes
// one multiplier bit per cycle. A word needs 21 multiplications when it follows the
// envelope and 23 under the hold gesture; that shared multiplier sets the rate. A new
// word is taken as soon as the previous one has been handed to the output register,
// which holds its result until the sink takes it. Knob registers are to be written
// through the plain write port only while the block is idle; the block itself does
// not enforce this. Indexes beyond the six knobs are ignored.

module envelope_sample_hold_dual_svf
    import eshsvf_pkg::*;
#(
    parameter int GATE_LENGTH     = 1600,
    parameter int QUALIFY_SAMPLES = 240
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    eshsvf_in_if.sink             i_in,
    eshsvf_out_if.source          o_out
);

    localparam int GW = $clog2(GATE_LENGTH + 1);
    localparam int QW = $clog2(QUALIFY_SAMPLES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_BASE, S_DEPTH, S_DAMP, S_SENS, S_CURVE, S_PERIOD, S_GAIN,
        S_ENV, S_E_SPAN, S_E_RATIO0, S_E_CUT0, S_E_RATIO1, S_E_CUT1,
        S_H_RATIO, S_H_OCT, S_H_PD, S_H_CUT,
        S_F_START, S_F_NOTCH, S_F_BAND, S_F_LOW,
        S_W_LEFT, S_W_RIGHT, S_P_SWEEP, S_P_RIGHT, S_P_LEFT, S_OUT
    } t_state;

    // Knob registers.
    logic [11:0] r_range, r_depth_k, r_res, r_sens_k, r_gain_k, r_slow;

    // Sequencer and multiplier link.
    t_state   r_state, r_ret;
    t_mul_req r_mreq;
    t_mul_rsp w_mrsp;

    // Latched input word.
    logic signed [11:0] r_audio, r_aux, r_cva, r_cvb;
    logic               r_clk_lvl, r_edge, r_gesture;

    // Persistent state.
    logic        [11:0] r_env;
    logic signed [11:0] r_held;
    logic        [15:0] r_pcnt;
    logic        [31:0] r_rng;
    logic        [1:0]  r_div;
    logic [GW-1:0]      r_ghold;
    logic [QW-1:0]      r_qual;
    logic               r_seen_low, r_prior_clk;
    logic        [11:0] r_pan;
    logic               r_pan_right;
    logic signed [15:0] r_low  [2];
    logic signed [15:0] r_band [2];

    // Per-word working registers.
    logic        [11:0] r_base, r_dep, r_sns, r_gain, r_cut0, r_cut1, r_sweep;
    logic        [10:0] r_damp, r_fd;
    logic        [15:0] r_period;
    logic        [13:0] r_span, r_oct;
    logic               r_k;
    logic signed [15:0] r_wl, r_wr;

    // Output register.
    logic               r_ovalid;
    logic signed [11:0] r_o_left, r_o_right, r_o_held;
    logic        [11:0] r_o_env;
    logic               r_o_clk, r_o_gate;

    eshsvf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (w_mrsp)
    );

    function automatic logic [31:0] xorshift(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic signed [11:0] soft_clip(input logic signed [15:0] s);
        logic signed [19:0] v;
        v = 20'(s);
        if (v > 20'sd3072) v = 20'sd3072 + ((v - 20'sd3072) >>> 2);
        if (v < -20'sd3072) v = -20'sd3072 + ((v + 20'sd3072) >>> 2);
        return 12'(clamp20(v, -20'sd2048, 20'sd2047));
    endfunction

    // Product of the last multiplication, shifted down by twelve (floor).
    logic signed [19:0] w_hi;
    assign w_hi = $signed(w_mrsp.prod[31:12]);

    logic signed [19:0] w_absx, w_base_n, w_dep_n, w_damp_n, w_sens_n, w_period_n;
    logic signed [19:0] w_gain_n, w_driven, w_cut_n, w_baseh, w_hcut, w_hd;
    logic signed [19:0] w_notch, w_band_n, w_low_n;
    logic        [11:0] w_abs_a, w_env_n, w_uni, w_pan_n, w_cut_k;
    logic signed [11:0] w_held_n;
    logic        [16:0] w_pc_inc;
    logic               w_fire;
    logic        [31:0] w_rng_n;
    logic [QW-1:0]      w_qual_n;
    logic               w_seen_n, w_gate_active, w_accept;

    assign w_accept = i_in.valid && i_in.ready;

    // Control values from the knob products.
    always_comb begin
        w_absx     = (r_aux < 0) ? -sx12(r_aux) : sx12(r_aux);
        w_base_n   = clamp20(20'sd64 + w_hi + sx12(r_cva >>> 2) + sx12(r_aux >>> 3),
                             20'sd32, 20'sd3900);
        w_dep_n    = clamp20(20'sd256 + w_hi + sx12(r_cvb), 20'sd64, 20'sd4095);
        w_damp_n   = clamp20(20'sd1800 - w_hi - (w_absx >>> 4), 20'sd64, 20'sd1800);
        w_sens_n   = clamp20(20'sd256 + w_hi + sx12(r_cva >>> 2), 20'sd64, 20'sd3072);
        w_period_n = clamp20(20'sd960 + w_hi, 20'sd48, 20'sd48000);
        w_gain_n   = clamp20(20'sd1024 + w_hi, 20'sd512, 20'sd4095);
        w_abs_a    = 12'(w_absx);
        w_abs_a    = 12'((r_audio < 0) ? -sx12(r_audio) : sx12(r_audio));
        if (w_abs_a < 12'd4) w_abs_a = '0;
        w_driven   = clamp20($signed(w_mrsp.prod[29:10]), 20'sd0, 20'sd4095);
        w_cut_n    = clamp20(w_hi, 20'sd64, 20'sd3900);
        w_baseh    = clamp20(20'(r_base), 20'sd256, 20'sd3900);
        w_hcut     = clamp20(w_baseh + w_hi, 20'sd64, 20'sd3900);
        w_hd       = clamp20(20'(r_damp) + 20'sd192, 20'sd384, 20'sd1800);
    end

    // Envelope follower, sample-and-hold timer and gate qualification.
    always_comb begin
        if (w_driven > 20'(r_env)) begin
            w_env_n = r_env + 12'((w_driven - 20'(r_env)) >>> 3);
        end else if ((r_env >> 9) == '0 && r_env != '0) begin
            w_env_n = r_env - 12'd1;
        end else begin
            w_env_n = r_env - (r_env >> 9);
        end
        if (r_edge && w_env_n < 12'd512) w_env_n = 12'd512;

        w_pc_inc = {1'b0, r_pcnt} + 17'd1;
        w_fire   = r_edge || (w_pc_inc >= {1'b0, r_period});
        w_rng_n  = xorshift(r_rng);
        w_held_n = w_fire ? {~w_rng_n[31], w_rng_n[30:20]} : r_held;
        w_uni    = {~w_held_n[11], w_held_n[10:0]};

        w_qual_n      = r_qual;
        w_seen_n      = r_seen_low;
        w_gate_active = 1'b0;
        if (!i_in.hold_gate) begin
            w_seen_n = 1'b1;
            w_qual_n = '0;
        end else if (r_seen_low) begin
            if (r_qual < QW'(QUALIFY_SAMPLES)) w_qual_n = r_qual + 1'b1;
            w_gate_active = (w_qual_n >= QW'(QUALIFY_SAMPLES));
        end
    end

    // Filter arithmetic for the filter selected by r_k, and the pan glide.
    always_comb begin
        w_cut_k  = r_k ? r_cut1 : r_cut0;
        w_notch  = sx12(r_audio) - 20'(r_low[r_k]) - w_hi;
        w_band_n = clamp20(20'(r_band[r_k]) + w_hi, -20'sd32768, 20'sd32767);
        w_low_n  = clamp20(20'(r_low[r_k]) + w_hi, -20'sd32768, 20'sd32767);
        if (r_pan_right) begin
            w_pan_n = (r_pan > 12'd4047) ? 12'd4095 : r_pan + 12'd48;
        end else begin
            w_pan_n = (r_pan > 12'd48) ? r_pan - 12'd48 : 12'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_mreq      <= '0;
            r_range     <= 12'd2048;
            r_depth_k   <= 12'd2048;
            r_res       <= 12'd2048;
            r_sens_k    <= 12'd1536;
            r_gain_k    <= 12'd0;
            r_slow      <= 12'd2048;
            r_env       <= '0;
            r_held      <= '0;
            r_pcnt      <= '0;
            r_rng       <= RNG_SEED;
            r_div       <= '0;
            r_ghold     <= '0;
            r_qual      <= '0;
            r_seen_low  <= 1'b0;
            r_prior_clk <= 1'b0;
            r_pan       <= '0;
            r_pan_right <= 1'b0;
            r_low[0]    <= '0;
            r_low[1]    <= '0;
            r_band[0]   <= '0;
            r_band[1]   <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            if (o_out.ready) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RANGE:       r_range   <= i_cfg_data;
                    CFG_DEPTH:       r_depth_k <= i_cfg_data;
                    CFG_RESONANCE:   r_res     <= i_cfg_data;
                    CFG_SENSITIVITY: r_sens_k  <= i_cfg_data;
                    CFG_GAIN:        r_gain_k  <= i_cfg_data;
                    CFG_SLOW:        r_slow    <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_audio     <= i_in.audio_in;
                        r_aux       <= i_in.aux_in;
                        r_cva       <= i_in.cv_a;
                        r_cvb       <= i_in.cv_b;
                        r_clk_lvl   <= i_in.clock_in;
                        r_edge      <= i_in.clock_in && !r_prior_clk;
                        r_prior_clk <= i_in.clock_in;
                        r_qual      <= w_qual_n;
                        r_seen_low  <= w_seen_n;
                        r_gesture   <= i_in.hold_switch || w_gate_active;
                        r_k         <= 1'b0;
                        r_mreq      <= '{1'b1, 18'sd3488, 14'(r_range)};
                        r_ret       <= S_BASE;
                        r_state     <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_mrsp.done) r_state <= r_ret;
                end
                S_BASE: begin
                    r_base  <= 12'(w_base_n);
                    r_mreq  <= '{1'b1, 18'sd3200, 14'(r_depth_k)};
                    r_ret   <= S_DEPTH;
                    r_state <= S_WAIT;
                end
                S_DEPTH: begin
                    r_dep   <= 12'(w_dep_n);
                    r_mreq  <= '{1'b1, 18'sd1500, 14'(r_res)};
                    r_ret   <= S_DAMP;
                    r_state <= S_WAIT;
                end
                S_DAMP: begin
                    r_damp  <= 11'(w_damp_n);
                    r_mreq  <= '{1'b1, 18'sd2816, 14'(r_sens_k)};
                    r_ret   <= S_SENS;
                    r_state <= S_WAIT;
                end
                S_SENS: begin
                    r_sns   <= 12'(w_sens_n);
                    r_mreq  <= '{1'b1, 18'(12'd4095 - r_slow), 14'(12'd4095 - r_slow)};
                    r_ret   <= S_CURVE;
                    r_state <= S_WAIT;
                end
                S_CURVE: begin
                    r_mreq  <= '{1'b1, 18'sd23040, 14'(w_hi[11:0])};
                    r_ret   <= S_PERIOD;
                    r_state <= S_WAIT;
                end
                S_PERIOD: begin
                    r_period <= 16'(w_period_n);
                    r_mreq   <= '{1'b1, 18'sd3072, 14'(r_gain_k)};
                    r_ret    <= S_GAIN;
                    r_state  <= S_WAIT;
                end
                S_GAIN: begin
                    r_gain  <= 12'(w_gain_n);
                    r_mreq  <= '{1'b1, 18'(w_abs_a), 14'(r_sns)};
                    r_ret   <= S_ENV;
                    r_state <= S_WAIT;
                end
                S_ENV: begin
                    r_env <= w_env_n;
                    if (w_fire) begin
                        r_pcnt      <= '0;
                        r_rng       <= w_rng_n;
                        r_held      <= w_held_n;
                        r_pan_right <= !r_pan_right;
                        r_div       <= r_div + 2'd1;
                        if (r_div == 2'd3) r_ghold <= GW'(GATE_LENGTH);
                    end else begin
                        r_pcnt <= w_pc_inc[15:0];
                    end
                    if (r_gesture) begin
                        r_mreq <= '{1'b1, 18'(w_uni), 14'd6144};
                        r_ret  <= S_H_RATIO;
                    end else begin
                        r_mreq <= '{1'b1, 18'sd12288, 14'(r_dep)};
                        r_ret  <= S_E_SPAN;
                    end
                    r_state <= S_WAIT;
                end
                S_E_SPAN: begin
                    r_span  <= w_hi[13:0];
                    r_mreq  <= '{1'b1, 18'(r_env), w_hi[13:0]};
                    r_ret   <= S_E_RATIO0;
                    r_state <= S_WAIT;
                end
                S_E_RATIO0: begin
                    r_mreq  <= '{1'b1, 18'(r_base), 14'(20'sd4096 + w_hi)};
                    r_ret   <= S_E_CUT0;
                    r_state <= S_WAIT;
                end
                S_E_CUT0: begin
                    r_cut0  <= 12'(w_cut_n);
                    r_mreq  <= '{1'b1, 18'(12'd4095 - r_env), r_span};
                    r_ret   <= S_E_RATIO1;
                    r_state <= S_WAIT;
                end
                S_E_RATIO1: begin
                    r_mreq  <= '{1'b1, 18'(r_base), 14'(20'sd4096 + w_hi)};
                    r_ret   <= S_E_CUT1;
                    r_state <= S_WAIT;
                end
                S_E_CUT1: begin
                    r_cut1  <= 12'(w_cut_n);
                    r_fd    <= r_damp;
                    r_state <= S_F_START;
                end
                S_H_RATIO: begin
                    r_mreq  <= '{1'b1, 18'(w_baseh), 14'(20'sd1024 + w_hi)};
                    r_ret   <= S_H_OCT;
                    r_state <= S_WAIT;
                end
                S_H_OCT: begin
                    r_oct   <= w_hi[13:0];
                    r_mreq  <= '{1'b1, 18'sd3456, 14'(r_dep)};
                    r_ret   <= S_H_PD;
                    r_state <= S_WAIT;
                end
                S_H_PD: begin
                    r_mreq  <= '{1'b1, 18'(20'(r_oct) - w_baseh), 14'(20'sd640 + w_hi)};
                    r_ret   <= S_H_CUT;
                    r_state <= S_WAIT;
                end
                S_H_CUT: begin
                    r_cut0  <= 12'(w_hcut);
                    r_cut1  <= 12'(w_hcut);
                    r_fd    <= 11'(w_hd);
                    r_state <= S_F_START;
                end
                S_F_START: begin
                    r_mreq  <= '{1'b1, 18'(r_band[r_k]), 14'(r_fd)};
                    r_ret   <= S_F_NOTCH;
                    r_state <= S_WAIT;
                end
                S_F_NOTCH: begin
                    r_mreq  <= '{1'b1, 18'(w_notch), 14'(w_cut_k)};
                    r_ret   <= S_F_BAND;
                    r_state <= S_WAIT;
                end
                S_F_BAND: begin
                    r_band[r_k] <= 16'(w_band_n);
                    r_mreq      <= '{1'b1, 18'(w_band_n), 14'(w_cut_k)};
                    r_ret       <= S_F_LOW;
                    r_state     <= S_WAIT;
                end
                S_F_LOW: begin
                    r_low[r_k] <= 16'(w_low_n);
                    if (!r_k) begin
                        r_k     <= 1'b1;
                        r_state <= S_F_START;
                    end else begin
                        r_mreq  <= '{1'b1, 18'(r_low[0]), 14'(r_gain)};
                        r_ret   <= S_W_LEFT;
                        r_state <= S_WAIT;
                    end
                end
                S_W_LEFT: begin
                    r_wl    <= w_hi[15:0];
                    r_mreq  <= '{1'b1, 18'(r_low[1]), 14'(r_gain)};
                    r_ret   <= S_W_RIGHT;
                    r_state <= S_WAIT;
                end
                S_W_RIGHT: begin
                    r_wr <= w_hi[15:0];
                    if (r_gesture) begin
                        r_pan   <= w_pan_n;
                        r_mreq  <= '{1'b1, 18'sd3071, 14'(w_pan_n)};
                        r_ret   <= S_P_SWEEP;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_P_SWEEP: begin
                    r_sweep <= w_hi[11:0];
                    r_mreq  <= '{1'b1, 18'(r_wl), 14'(12'd1024 + w_hi[11:0])};
                    r_ret   <= S_P_RIGHT;
                    r_state <= S_WAIT;
                end
                S_P_RIGHT: begin
                    r_wr    <= w_hi[15:0];
                    r_mreq  <= '{1'b1, 18'(r_wl), 14'(12'd4095 - r_sweep)};
                    r_ret   <= S_P_LEFT;
                    r_state <= S_WAIT;
                end
                S_P_LEFT: begin
                    r_wl    <= w_hi[15:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hand over only once the output register is free.
                    if (!r_ovalid || o_out.ready) begin
                        r_o_left  <= soft_clip(r_wl);
                        r_o_right <= soft_clip(r_wr);
                        r_o_held  <= r_held;
                        r_o_env   <= r_env;
                        r_o_clk   <= r_clk_lvl;
                        r_o_gate  <= (r_ghold != '0);
                        r_ovalid  <= 1'b1;
                        if (r_ghold != '0) r_ghold <= r_ghold - 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.out_left    = r_o_left;
    assign o_out.out_right   = r_o_right;
    assign o_out.held_cv     = r_o_held;
    assign o_out.envelope_cv = r_o_env;
    assign o_out.clock_out   = r_o_clk;
    assign o_out.gate_out    = r_o_gate;

`ifndef SYNTH
    // A taken word keeps the input closed while its work is under way.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input ready straight after a word was taken");

    // The sequencer never restarts the multiplier in the middle of a product.
    a_mul_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mreq.start |-> !w_mrsp.busy)
        else $error("multiplier started while busy");

    a_qual_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qual <= QW'(QUALIFY_SAMPLES))
        else $error("qualify counter beyond its limit");

    a_gate_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ghold <= GW'(GATE_LENGTH))
        else $error("gate hold counter beyond its length");

    // The output word is only reloaded once the previous one has left.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && !o_out.ready) |=> (r_state == S_OUT))
        else $error("pending output word overwritten");
`endif

endmodule

### rtl/core/eshsvf_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module eshsvf_mul
    import eshsvf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [MUL_P_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_P_W-1:0]   r_acc;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a   <= {{(MUL_P_W - MUL_A_W){i_req.a[MUL_A_W-1]}}, i_req.a};
                r_b   <= i_req.b;
                r_acc <= '0;
                r_cnt <= MUL_CNT_W'(MUL_B_W);
            end else if (r_cnt != '0) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a    <= r_a << 1;
                r_b    <= r_b >> 1;
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == MUL_CNT_W'(1));
            end
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule
